FILE: design/vvtp_pkg.sv
// Package for the vertex view transform: payload words, register indexes and helpers.
package vvtp_pkg;

	// Screen centre in pixels.
	localparam int CENTER_COL  = 640;
	localparam int CENTER_ROW  = 360;
	localparam int NEAR_DEPTH  = 26;

	// Quotient bits of the projection divide.
	localparam int DIV_STEPS = 55;

	localparam logic signed [63:0] CENTER_X = 64'(CENTER_COL * 256);
	localparam logic signed [63:0] CENTER_Y = 64'(CENTER_ROW * 256);

	typedef enum logic [2:0] {
		CFG_CAMERA_X     = 3'd0,
		CFG_CAMERA_Y     = 3'd1,
		CFG_CAMERA_Z     = 3'd2,
		CFG_YAW_COSINE   = 3'd3,
		CFG_YAW_SINE     = 3'd4,
		CFG_PITCH_COSINE = 3'd5,
		CFG_PITCH_SINE   = 3'd6,
		CFG_FOCAL_LENGTH = 3'd7
	} cfg_index_t;

	typedef struct packed {
		logic [11:0] local_x;
		logic [15:0] local_y;
		logic [11:0] local_z;
		logic [23:0] chunk_origin_x;
		logic [23:0] chunk_origin_z;
		logic [15:0] tex_u;
		logic [15:0] tex_v;
	} in_word_t;

	typedef struct packed {
		logic        visible;
		logic [31:0] view_x;
		logic [31:0] view_y;
		logic [31:0] view_depth;
		logic [31:0] screen_x;
		logic [31:0] screen_y;
		logic [15:0] out_tex_u;
		logic [15:0] out_tex_v;
	} out_word_t;

	typedef struct packed {
		logic        vis;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vd;
		logic [15:0] tex_u;
		logic [15:0] tex_v;
		logic        negx;
		logic        negy;
		logic [DIV_STEPS-1:0] numx;
		logic [31:0] remx;
		logic [DIV_STEPS-1:0] numy;
		logic [31:0] remy;
	} div_word_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: design/vertex_view_transform_project_unit.sv
// Top level: pipelined view transform, rotation and perspective divide of mesh vertices.
//
// Words enter on in_valid/in_ready as a vvtp_pkg::in_word_t and leave on
// out_valid/out_ready as a vvtp_pkg::out_word_t, one result word per input word.
// Camera position, yaw and pitch trigonometry and focal length are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while no
// word is in flight, as the block itself does not enforce this. A word passes
// 63 registers: six stages for the translation, the two rotations and the focal
// products, one stage to take magnitudes, 55 stages of the bit-per-stage
// restoring divider, and the output register. One word can enter every cycle
// while the pipeline is not stalled. Each stage holds its word only while the
// stage after it is full and stalled, so a stalled receiver fills the empty
// stages first and in_ready drops only when every stage holds a word. Nothing
// is dropped or repeated. Reset clears all valid bits and returns the registers
// to an identity camera at the origin with a focal length of 256 pixels.
module vertex_view_transform_project_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  vvtp_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vvtp_pkg::out_word_t  out_data,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int N = vvtp_pkg::DIV_STEPS;

	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic signed [15:0] yc_q, ys_q, pc_q, ps_q;
	logic [23:0]        focal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			yc_q    <= 16'sd16384;
			ys_q    <= '0;
			pc_q    <= 16'sd16384;
			ps_q    <= '0;
			focal_q <= 24'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vvtp_pkg::CFG_CAMERA_X:     cam_x_q <= cfg_data;
				vvtp_pkg::CFG_CAMERA_Y:     cam_y_q <= cfg_data;
				vvtp_pkg::CFG_CAMERA_Z:     cam_z_q <= cfg_data;
				vvtp_pkg::CFG_YAW_COSINE:   yc_q    <= cfg_data[15:0];
				vvtp_pkg::CFG_YAW_SINE:     ys_q    <= cfg_data[15:0];
				vvtp_pkg::CFG_PITCH_COSINE: pc_q    <= cfg_data[15:0];
				vvtp_pkg::CFG_PITCH_SINE:   ps_q    <= cfg_data[15:0];
				vvtp_pkg::CFG_FOCAL_LENGTH: focal_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Valid bits and stage enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_out;
	logic [N:0] v_d, en_d;
	logic out_valid_q;

	assign en_out = !out_valid_q || out_ready;
	assign en_s6  = !v_s6 || en_d[0];
	assign en_s5  = !v_s5 || en_s6;
	assign en_s4  = !v_s4 || en_s5;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// Stage 1: translation into camera-relative position.
	logic signed [33:0] tx_s1, ty_s1, tz_s1;
	logic [15:0] tu_s1, tv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			tx_s1 <= $signed({{2{in_data.chunk_origin_x[23]}}, in_data.chunk_origin_x, 8'h00})
				+ $signed({22'd0, in_data.local_x}) - 34'(cam_x_q);
			ty_s1 <= $signed({18'd0, in_data.local_y}) - 34'(cam_y_q);
			tz_s1 <= $signed({{2{in_data.chunk_origin_z[23]}}, in_data.chunk_origin_z, 8'h00})
				+ $signed({22'd0, in_data.local_z}) - 34'(cam_z_q);
			tu_s1 <= in_data.tex_u;
			tv_s1 <= in_data.tex_v;
		end
	end

	// Stage 2: trigonometry products.
	logic signed [49:0] txyc_s2, tzys_s2, txys_s2, tzyc_s2, typc_s2, typs_s2;
	logic [15:0] tu_s2, tv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			txyc_s2 <= tx_s1 * yc_q;
			tzys_s2 <= tz_s1 * ys_q;
			txys_s2 <= tx_s1 * ys_q;
			tzyc_s2 <= tz_s1 * yc_q;
			typc_s2 <= ty_s1 * pc_q;
			typs_s2 <= ty_s1 * ps_q;
			tu_s2   <= tu_s1;
			tv_s2   <= tv_s1;
		end
	end

	// Stage 3: yaw rotation sums.
	logic signed [50:0] xr_s3, zr_s3;
	logic signed [49:0] typc_s3, typs_s3;
	logic [15:0] tu_s3, tv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			xr_s3   <= 51'(txyc_s2) - 51'(tzys_s2);
			zr_s3   <= 51'(txys_s2) + 51'(tzyc_s2);
			typc_s3 <= typc_s2;
			typs_s3 <= typs_s2;
			tu_s3   <= tu_s2;
			tv_s3   <= tv_s2;
		end
	end

	// Stage 4: pitch products of the exact yaw depth, and rounding of view x.
	logic signed [51:0] xr_rnd;
	logic signed [66:0] zrps_full, zrpc_full;
	logic [31:0] vx_s4;
	logic [63:0] zrps_s4, zrpc_s4;
	logic signed [49:0] typc_s4, typs_s4;
	logic [15:0] tu_s4, tv_s4;

	assign xr_rnd    = 52'(xr_s3) + 52'sd8192;
	assign zrps_full = zr_s3 * ps_q;
	assign zrpc_full = zr_s3 * pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			vx_s4   <= vvtp_pkg::sat32(64'(xr_rnd) >>> 14);
			zrps_s4 <= zrps_full[63:0];
			zrpc_s4 <= zrpc_full[63:0];
			typc_s4 <= typc_s3;
			typs_s4 <= typs_s3;
			tu_s4   <= tu_s3;
			tv_s4   <= tv_s3;
		end
	end

	// Stage 5: pitch sums, rounding and saturation. Sums wrap at 64 bits.
	logic signed [63:0] py_sum, pz_sum;
	logic [31:0] vx_s5, vy_s5, vd_s5;
	logic [15:0] tu_s5, tv_s5;

	assign py_sum = $signed({typc_s4, 14'd0}) - $signed(zrps_s4) + 64'sd134217728;
	assign pz_sum = $signed({typs_s4, 14'd0}) + $signed(zrpc_s4) + 64'sd134217728;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			vx_s5 <= vx_s4;
			vy_s5 <= vvtp_pkg::sat32(py_sum >>> 28);
			vd_s5 <= vvtp_pkg::sat32(pz_sum >>> 28);
			tu_s5 <= tu_s4;
			tv_s5 <= tv_s4;
		end
	end

	// Stage 6: focal products and near plane test.
	logic signed [56:0] fx_full, fy_full;
	logic signed [55:0] px_s6, py_s6;
	logic vis_s6;
	logic [31:0] vx_s6, vy_s6, vd_s6;
	logic [15:0] tu_s6, tv_s6;

	assign fx_full = $signed(vx_s5) * $signed({1'b0, focal_q});
	assign fy_full = $signed(vy_s5) * $signed({1'b0, focal_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en_s6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			px_s6  <= fx_full[55:0];
			py_s6  <= fy_full[55:0];
			vis_s6 <= $signed(vd_s5) >= 32'(vvtp_pkg::NEAR_DEPTH);
			vx_s6  <= vx_s5;
			vy_s6  <= vy_s5;
			vd_s6  <= vd_s5;
			tu_s6  <= tu_s5;
			tv_s6  <= tv_s5;
		end
	end

	// Divider entry: magnitudes and signs; the divisor is positive when visible.
	vvtp_pkg::div_word_t div_s [0:N];
	logic [55:0] magx, magy;

	assign magx = px_s6[55] ? 56'(-px_s6) : px_s6;
	assign magy = py_s6[55] ? 56'(-py_s6) : py_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d[0] <= 1'b0;
		end else if (en_d[0]) begin
			v_d[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_d[0]) begin
			div_s[0].vis   <= vis_s6;
			div_s[0].vx    <= vx_s6;
			div_s[0].vy    <= vy_s6;
			div_s[0].vd    <= vd_s6;
			div_s[0].tex_u <= tu_s6;
			div_s[0].tex_v <= tv_s6;
			div_s[0].negx  <= px_s6[55];
			div_s[0].negy  <= py_s6[55];
			div_s[0].numx  <= magx[N-1:0];
			div_s[0].remx  <= '0;
			div_s[0].numy  <= magy[N-1:0];
			div_s[0].remy  <= '0;
		end
	end

	// Restoring divider, one quotient bit per stage. The numerator shifts out
	// at the top while quotient bits shift in at the bottom.
	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_div
			logic [31:0] tx_trial, ty_trial, dsr;
			logic        gex, gey;
			vvtp_pkg::div_word_t nxt_w;

			assign en_d[k] = !v_d[k] || en_d[k+1];
			assign dsr      = {1'b0, div_s[k].vd[30:0]};
			assign tx_trial = {div_s[k].remx[30:0], div_s[k].numx[N-1]};
			assign ty_trial = {div_s[k].remy[30:0], div_s[k].numy[N-1]};
			assign gex      = tx_trial >= dsr;
			assign gey      = ty_trial >= dsr;

			always_comb begin
				nxt_w      = div_s[k];
				nxt_w.remx = gex ? tx_trial - dsr : tx_trial;
				nxt_w.remy = gey ? ty_trial - dsr : ty_trial;
				nxt_w.numx = {div_s[k].numx[N-2:0], gex};
				nxt_w.numy = {div_s[k].numy[N-2:0], gey};
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_d[k+1] <= 1'b0;
				end else if (en_d[k+1]) begin
					v_d[k+1] <= v_d[k];
				end
			end

			always_ff @(posedge clk) begin
				if (en_d[k+1]) begin
					div_s[k+1] <= nxt_w;
				end
			end
		end
	endgenerate

	assign en_d[N] = !v_d[N] || en_out;

	// Output register: sign, screen centre and saturation; hidden vertices get a zero screen position.
	logic signed [63:0] qx, qy;
	vvtp_pkg::out_word_t out_q;

	assign qx = div_s[N].negx ? -$signed(64'(div_s[N].numx)) : $signed(64'(div_s[N].numx));
	assign qy = div_s[N].negy ? -$signed(64'(div_s[N].numy)) : $signed(64'(div_s[N].numy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_d[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_q.visible    <= div_s[N].vis;
			out_q.view_x     <= div_s[N].vx;
			out_q.view_y     <= div_s[N].vy;
			out_q.view_depth <= div_s[N].vd;
			out_q.screen_x   <= div_s[N].vis ? vvtp_pkg::sat32(vvtp_pkg::CENTER_X + qx) : '0;
			out_q.screen_y   <= div_s[N].vis ? vvtp_pkg::sat32(vvtp_pkg::CENTER_Y - qy) : '0;
			out_q.out_tex_u  <= div_s[N].tex_u;
			out_q.out_tex_v  <= div_s[N].tex_v;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_hidden_screen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.visible |-> out_data.screen_x == '0 && out_data.screen_y == '0)
		else $error("hidden vertex has nonzero screen position");

	a_visible_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.visible |->
			$signed(out_data.view_depth) >= 32'(vvtp_pkg::NEAR_DEPTH))
		else $error("visible vertex in front of near plane");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted word did not reach the first stage");
`endif

endmodule
